// ===== rtl/core/mhid_pkg.sv =====
// Shared types and constants for the max-heap block.
package mhid_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_READ,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_NOT_FOUND,
		ST_BAD_INDEX
	} stat_t;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [DATA_W-1:0] value;
		logic [5:0]               index;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data;
		logic [6:0]               count;
		logic signed [DATA_W-1:0] top;
		logic                     empty_res;
	} res_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LATCH,
		ACT_INSERT,
		ACT_FULL,
		ACT_READ_ISSUE,
		ACT_READ_TAKE,
		ACT_READ_BAD,
		ACT_SRCH_RD,
		ACT_SRCH_CMP,
		ACT_NOTFOUND,
		ACT_DEL_WR,
		ACT_RB_INIT,
		ACT_SD_LOAD,
		ACT_SD_CUR,
		ACT_SD_CMP,
		ACT_SD_CHRD
	} act_t;

	typedef struct packed {
		act_t act;
		logic done;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       idx_ok;
		logic       search_end;
		logic       match;
		logic       few;
		logic       swap;
		logic       k_zero;
	} dp_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RD_TAKE,
		S_SR_RD,
		S_SR_CMP,
		S_DL_WR,
		S_RB_INIT,
		S_SD_LOAD,
		S_SD_CUR,
		S_SD_CMP,
		S_SD_CHRD,
		S_FIN
	} state_t;

endpackage

// ===== rtl/core/mhid_dp.sv =====
// Datapath: heap memory, count, search and sift-down registers, result registers.
module mhid_dp import mhid_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     request,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat,
	output res_t     result
);

	logic [1:0]               op_q;
	logic signed [DATA_W-1:0] value_q;
	logic [IDX_W-1:0]         idx_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         k_q;
	logic [IDX_W-1:0]         node_q;
	logic signed [DATA_W-1:0] cur_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] data_q;
	logic [1:0]               status_q;

	logic signed [DATA_W-1:0] mem [CAPACITY];
	logic signed [DATA_W-1:0] rdata_a_q;
	logic signed [DATA_W-1:0] rdata_b_q;

	logic [IDX_W-1:0]         raddr_a;
	logic [IDX_W-1:0]         raddr_b;
	logic [IDX_W-1:0]         waddr;
	logic                     we;
	logic signed [DATA_W-1:0] wdata;

	logic [CNT_W:0]           lc;
	logic [CNT_W:0]           rc;
	logic                     lc_ok;
	logic                     rc_ok;
	logic signed [DATA_W-1:0] best_val;
	logic [IDX_W-1:0]         best_idx;
	logic                     swap;
	logic [IDX_W-1:0]         last_idx;

	assign lc       = {1'b0, node_q, 1'b1};
	assign rc       = lc + (CNT_W+1)'(1);
	assign lc_ok    = lc < {1'b0, count_q};
	assign rc_ok    = rc < {1'b0, count_q};
	assign last_idx = IDX_W'(count_q - CNT_W'(1));

	// strict compares: ties keep the parent, then the left child
	always_comb begin
		best_val = cur_q;
		best_idx = node_q;
		swap     = 1'b0;
		if (lc_ok && (rdata_a_q > best_val)) begin
			best_val = rdata_a_q;
			best_idx = lc[IDX_W-1:0];
			swap     = 1'b1;
		end
		if (rc_ok && (rdata_b_q > best_val)) begin
			best_val = rdata_b_q;
			best_idx = rc[IDX_W-1:0];
			swap     = 1'b1;
		end
	end

	always_comb begin
		case (cmd.act)
			ACT_READ_ISSUE:          raddr_a = idx_q;
			ACT_SRCH_RD, ACT_SD_LOAD: raddr_a = k_q[IDX_W-1:0];
			ACT_SRCH_CMP:            raddr_a = last_idx;
			ACT_SD_CUR, ACT_SD_CHRD: raddr_a = lc[IDX_W-1:0];
			default:                 raddr_a = '0;
		endcase
		raddr_b = rc[IDX_W-1:0];
	end

	// sift-down carries a hole: the moving value is written once, where it settles
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = value_q;
		case (cmd.act)
			ACT_INSERT: begin
				we    = 1'b1;
				waddr = count_q[IDX_W-1:0];
				wdata = value_q;
			end
			ACT_DEL_WR: begin
				we    = 1'b1;
				waddr = k_q[IDX_W-1:0];
				wdata = rdata_a_q;
			end
			ACT_SD_CMP: begin
				we    = 1'b1;
				waddr = node_q;
				wdata = swap ? best_val : cur_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == '0)) begin
			top_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.act)
				ACT_INSERT: count_q <= count_q + CNT_W'(1);
				ACT_DEL_WR: count_q <= count_q - CNT_W'(1);
				default:    count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.act)
			ACT_LATCH: begin
				op_q     <= request.operation;
				value_q  <= request.value;
				idx_q    <= request.index;
				status_q <= ST_OK;
				data_q   <= '0;
				k_q      <= '0;
			end
			ACT_FULL:      status_q <= ST_FULL;
			ACT_READ_BAD:  status_q <= ST_BAD_INDEX;
			ACT_NOTFOUND:  status_q <= ST_NOT_FOUND;
			ACT_READ_TAKE: data_q   <= rdata_a_q;
			ACT_SRCH_CMP: begin
				if (rdata_a_q == value_q) begin
					data_q <= rdata_a_q;
				end else begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			ACT_RB_INIT: k_q    <= (count_q >> 1) - CNT_W'(1);
			ACT_SD_LOAD: node_q <= k_q[IDX_W-1:0];
			ACT_SD_CUR:  cur_q  <= rdata_a_q;
			ACT_SD_CMP: begin
				if (swap) begin
					node_q <= best_idx;
				end else if (k_q != '0) begin
					k_q <= k_q - CNT_W'(1);
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	assign stat.op         = op_q;
	assign stat.full       = count_q == CNT_W'(CAPACITY);
	assign stat.idx_ok     = {1'b0, idx_q} < count_q;
	assign stat.search_end = k_q >= count_q;
	assign stat.match      = rdata_a_q == value_q;
	assign stat.few        = count_q < CNT_W'(2);
	assign stat.swap       = swap;
	assign stat.k_zero     = k_q == '0;

	assign result.status    = status_q;
	assign result.data      = data_q;
	assign result.count     = count_q;
	assign result.top       = (count_q != '0) ? top_q : '0;
	assign result.empty_res = count_q == '0;

endmodule

// ===== rtl/core/mhid_ctrl.sv =====
// Controller: sequences insert, delete search, read and heap rebuild.
module mhid_ctrl import mhid_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output logic     busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.act  = ACT_NONE;
		cmd.done = 1'b0;
		busy     = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.act = ACT_LATCH;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							cmd.act = ACT_FULL;
							state_d = S_FIN;
						end else begin
							cmd.act = ACT_INSERT;
							state_d = S_RB_INIT;
						end
					end
					OP_DELETE: state_d = S_SR_RD;
					OP_READ: begin
						if (stat.idx_ok) begin
							cmd.act = ACT_READ_ISSUE;
							state_d = S_RD_TAKE;
						end else begin
							cmd.act = ACT_READ_BAD;
							state_d = S_FIN;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_RD_TAKE: begin
				cmd.act = ACT_READ_TAKE;
				state_d = S_FIN;
			end
			S_SR_RD: begin
				if (stat.search_end) begin
					cmd.act = ACT_NOTFOUND;
					state_d = S_FIN;
				end else begin
					cmd.act = ACT_SRCH_RD;
					state_d = S_SR_CMP;
				end
			end
			S_SR_CMP: begin
				// also fetches the last entry, used only on a hit
				cmd.act = ACT_SRCH_CMP;
				state_d = stat.match ? S_DL_WR : S_SR_RD;
			end
			S_DL_WR: begin
				cmd.act = ACT_DEL_WR;
				state_d = S_RB_INIT;
			end
			S_RB_INIT: begin
				if (stat.few) begin
					state_d = S_FIN;
				end else begin
					cmd.act = ACT_RB_INIT;
					state_d = S_SD_LOAD;
				end
			end
			S_SD_LOAD: begin
				cmd.act = ACT_SD_LOAD;
				state_d = S_SD_CUR;
			end
			S_SD_CUR: begin
				cmd.act = ACT_SD_CUR;
				state_d = S_SD_CMP;
			end
			S_SD_CMP: begin
				cmd.act = ACT_SD_CMP;
				if (stat.swap) begin
					state_d = S_SD_CHRD;
				end else if (stat.k_zero) begin
					state_d = S_FIN;
				end else begin
					state_d = S_SD_LOAD;
				end
			end
			S_SD_CHRD: begin
				cmd.act = ACT_SD_CHRD;
				state_d = S_SD_CMP;
			end
			S_FIN: begin
				cmd.done = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/max_heap_insert_delete.sv =====
// Top level of the binary max-heap: controller plus datapath.
//
//  channel   ports                    beat taken when
//  request   start, busy, request     rising edge with start high, busy low
//  result    done, result             rising edge ending the cycle done is high
//
// From accept to done: a read issues the memory read, then takes the data; a bad read,
// a full insert or a no-op goes straight to done. Insert writes the new entry at the
// end, then rebuilds. Delete searches entry by entry: a miss ends there, a hit writes
// the last entry over the match and rebuilds. Rebuild sifts each internal node down.
// Reset clears the count and returns the controller to idle; memory contents are left as they are.
// The receiver cannot stall: done is high for exactly one cycle, busy drops after.
module max_heap_insert_delete import mhid_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output res_t result
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	mhid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	mhid_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

	assign done = cmd.done;

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("result beat not followed by idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not make block busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.count <= 7'(CAPACITY)))
		else $error("count beyond capacity");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.empty_res == (result.count == '0)))
		else $error("empty flag disagrees with count");

endmodule
